// ===== rtl/itpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpa_pkg
// Shared types and constants for the integer to padded ascii unit.
// ----------------------------------------------------------------------------
package itpa_pkg;

  // radix codes of the base_select register
  localparam logic [1:0] BASE_BIN = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_DEC = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // configuration register indexes
  localparam logic CFG_IDX_BASE = 1'b0;
  localparam logic CFG_IDX_PAD  = 1'b1;

  localparam int CFG_DATA_W = 7;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
  localparam int OUT_W     = 9;

  // classification of one request
  typedef struct packed {
    logic       neg;
    logic [1:0] base;
  } job_ctrl_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== rtl/itpa_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpa_fifo
// Small register queue with occupancy count, used between the stages.
// ----------------------------------------------------------------------------
module itpa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             pop_data,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign count    = cnt_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/itpa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpa_front
// Configuration registers and request classification: sign, magnitude,
// radix and saturated pad width.
// ----------------------------------------------------------------------------
module itpa_front #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [itpa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [VALUE_BITS-1:0]         value,
  output logic [VALUE_BITS-1:0]                job_mag,
  output itpa_pkg::job_ctrl_t                  job_ctrl,
  output logic [$clog2(MAX_WIDTH+1)-1:0]       job_width
);

  localparam int PW_W = $clog2(MAX_WIDTH + 1);

  logic [1:0]                      base_r;
  logic [itpa_pkg::CFG_DATA_W-1:0] pad_r;
  logic [VALUE_BITS-1:0]           raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= itpa_pkg::BASE_DEC;
      pad_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        itpa_pkg::CFG_IDX_BASE: base_r <= cfg_data[1:0];
        itpa_pkg::CFG_IDX_PAD:  pad_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign raw = value;

  always_comb begin
    job_ctrl.neg  = raw[VALUE_BITS-1];
    job_ctrl.base = base_r;
    job_mag       = raw[VALUE_BITS-1] ? ('0 - raw) : raw;
    if (pad_r > itpa_pkg::CFG_DATA_W'(MAX_WIDTH)) begin
      job_width = PW_W'(MAX_WIDTH);
    end else begin
      job_width = PW_W'(pad_r);
    end
  end

endmodule

// ===== rtl/itpa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpa_back
// Digit generation into the text store (shift-add bcd for decimal), prefix
// and sign, then padded emission into the result queue.
// ----------------------------------------------------------------------------
module itpa_back #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  output logic                                 job_pop,
  input  logic [VALUE_BITS-1:0]                job_mag,
  input  itpa_pkg::job_ctrl_t                  job_ctrl,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]       job_width,
  input  logic [itpa_pkg::OUT_CNT_W-1:0]       out_cnt,
  output logic                                 out_push,
  output logic [itpa_pkg::OUT_W-1:0]           out_data
);

  localparam int PW_W        = $clog2(MAX_WIDTH + 1);
  localparam int DEC_DIGITS  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int BC_W        = $clog2(VALUE_BITS + 1);
  localparam int STORE_DEPTH = VALUE_BITS + 4;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);
  localparam int CW          = (LEN_W > PW_W) ? LEN_W : PW_W;
  localparam int OCW         = itpa_pkg::OUT_CNT_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BCD  = 3'd1;
  localparam logic [2:0] S_DIG  = 3'd2;
  localparam logic [2:0] S_HX   = 3'd3;
  localparam logic [2:0] S_ZR   = 3'd4;
  localparam logic [2:0] S_SGN  = 3'd5;
  localparam logic [2:0] S_SET  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]       st_r, st_nxt;
  logic [BCD_W-1:0] work_r, work_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [BC_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             neg_r, neg_nxt;
  logic [1:0]       base_r, base_nxt;
  logic [PW_W-1:0]  width_r, width_nxt;
  logic [CW-1:0]    emit_left_r, emit_left_nxt;
  logic [CW-1:0]    pad_left_r, pad_left_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             p_vld_r, p_pad_r, p_last_r;
  logic [7:0]       rdata_r;

  logic [7:0]       store_mem [STORE_DEPTH];
  logic             st_we;
  logic [7:0]       st_wdata;

  logic [BCD_W-1:0] bcd_adj, bcd_shift, work_shift;
  logic [3:0]       digit;
  logic [CW-1:0]    len_x, w_x, tot, pad;
  logic             issue, issue_pad;
  logic [OCW-1:0]   occ;

  // shift-add-3 step
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                     : bcd_r[4*i +: 4];
    end
    bcd_shift = {bcd_adj[BCD_W-2:0], work_r[VALUE_BITS-1]};
  end

  always_comb begin
    case (base_r)
      itpa_pkg::BASE_BIN: begin
        digit      = {3'd0, work_r[0]};
        work_shift = work_r >> 1;
      end
      itpa_pkg::BASE_OCT: begin
        digit      = {1'b0, work_r[2:0]};
        work_shift = work_r >> 3;
      end
      default: begin
        digit      = work_r[3:0];
        work_shift = work_r >> 4;
      end
    endcase
  end

  always_comb begin
    len_x = CW'(len_r);
    w_x   = CW'(width_r);
    tot   = (len_x > w_x) ? len_x : w_x;
    if (tot > CW'(MAX_WIDTH)) begin
      tot = CW'(MAX_WIDTH);
    end
    pad = (tot > len_x) ? tot - len_x : '0;
  end

  assign occ       = OCW'(out_cnt) + OCW'(p_vld_r);
  assign issue     = (st_r == S_EMIT) && (occ < OCW'(itpa_pkg::OUT_DEPTH));
  assign issue_pad = (pad_left_r != '0);

  always_comb begin
    st_nxt        = st_r;
    work_nxt      = work_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    width_nxt     = width_r;
    emit_left_nxt = emit_left_r;
    pad_left_nxt  = pad_left_r;
    rd_idx_nxt    = rd_idx_r;
    job_pop       = 1'b0;
    st_we         = 1'b0;
    st_wdata      = itpa_pkg::CH_ZERO;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          work_nxt  = BCD_W'(job_mag);
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          len_nxt   = '0;
          neg_nxt   = job_ctrl.neg;
          base_nxt  = job_ctrl.base;
          width_nxt = job_width;
          st_nxt    = (job_ctrl.base == itpa_pkg::BASE_DEC) ? S_BCD : S_DIG;
        end
      end
      S_BCD: begin
        bcd_nxt  = bcd_shift;
        work_nxt = work_r << 1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == BC_W'(VALUE_BITS - 1)) begin
          work_nxt = bcd_shift;
          st_nxt   = S_DIG;
        end
      end
      S_DIG: begin
        st_we    = 1'b1;
        st_wdata = itpa_pkg::digit_char(digit);
        len_nxt  = len_r + 1'b1;
        work_nxt = work_shift;
        if (work_shift == '0) begin
          case (base_r)
            itpa_pkg::BASE_HEX: st_nxt = S_HX;
            itpa_pkg::BASE_OCT: st_nxt = S_ZR;
            default:            st_nxt = S_SGN;
          endcase
        end
      end
      S_HX: begin
        st_we    = 1'b1;
        st_wdata = itpa_pkg::CH_X;
        len_nxt  = len_r + 1'b1;
        st_nxt   = S_ZR;
      end
      S_ZR: begin
        st_we    = 1'b1;
        st_wdata = itpa_pkg::CH_ZERO;
        len_nxt  = len_r + 1'b1;
        st_nxt   = S_SGN;
      end
      S_SGN: begin
        if (neg_r) begin
          st_we    = 1'b1;
          st_wdata = itpa_pkg::CH_MINUS;
          len_nxt  = len_r + 1'b1;
        end
        st_nxt = S_SET;
      end
      S_SET: begin
        emit_left_nxt = tot;
        pad_left_nxt  = pad;
        rd_idx_nxt    = IDX_W'(len_r - 1'b1);
        st_nxt        = S_EMIT;
      end
      S_EMIT: begin
        if (issue) begin
          if (issue_pad) begin
            pad_left_nxt = pad_left_r - 1'b1;
          end else begin
            rd_idx_nxt = rd_idx_r - 1'b1;
          end
          emit_left_nxt = emit_left_r - 1'b1;
          if (emit_left_r == CW'(1)) begin
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      p_vld_r     <= 1'b0;
      emit_left_r <= '0;
      pad_left_r  <= '0;
    end else begin
      st_r        <= st_nxt;
      p_vld_r     <= issue;
      emit_left_r <= emit_left_nxt;
      pad_left_r  <= pad_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r   <= work_nxt;
    bcd_r    <= bcd_nxt;
    cnt_r    <= cnt_nxt;
    len_r    <= len_nxt;
    neg_r    <= neg_nxt;
    base_r   <= base_nxt;
    width_r  <= width_nxt;
    rd_idx_r <= rd_idx_nxt;
    if (issue) begin
      p_pad_r  <= issue_pad;
      p_last_r <= (emit_left_r == CW'(1));
    end
  end

  // text store, reverse order
  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[len_r[IDX_W-1:0]] <= st_wdata;
    end
    if (issue && !issue_pad) begin
      rdata_r <= store_mem[rd_idx_r];
    end
  end

  assign out_push = p_vld_r;
  assign out_data = {(p_pad_r ? itpa_pkg::CH_SPACE : rdata_r), p_last_r};

endmodule

// ===== rtl/int_to_padded_ascii_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_padded_ascii_unit
// Signed integer to right-justified ascii text in base 2, 8, 10 or 16.
//
// Input request: in_value is taken when in_push is high and in_full is low;
// a two-entry queue sits behind the input, so up to two values wait while
// one is being converted. Results: one character per queue entry on
// out_char_code, out_last_char marking the final one; a result is taken when
// out_pop is high and out_empty is low, and a four-entry result queue holds
// characters while the receiver stalls, the converter pausing when it fills.
// Configuration (base_select index 0, pad_width index 1) via cfg_we.
// Per value: a start step, then for decimal shift-add bcd over all VALUE_BITS
// input bits, then the digits (produced one a cycle by shifting), up to three
// steps for prefix and sign, one to size the padding, then one character a
// cycle out of the text store (one read port) while the result queue has
// room, through the read register and the result queue to the result ports;
// from then on one character a cycle while the receiver keeps up.
// Reset (synchronous, rst_n low) empties both queues and sets decimal radix
// with no padding; the text store needs no clearing.
// ----------------------------------------------------------------------------
module int_to_padded_ascii_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic signed [VALUE_BITS-1:0]       in_value,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [7:0]                         out_char_code,
  output logic                               out_last_char,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [itpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int PW_W  = $clog2(MAX_WIDTH + 1);
  localparam int JOB_W = VALUE_BITS + 3 + PW_W;
  localparam int JQ_DEPTH = 2;

  logic [VALUE_BITS-1:0]            f_mag, b_mag;
  itpa_pkg::job_ctrl_t              f_ctrl, b_ctrl;
  logic [PW_W-1:0]                  f_width, b_width;
  logic [JOB_W-1:0]                 jq_wdata, jq_rdata;
  logic                             jq_empty, jq_pop;
  logic [$clog2(JQ_DEPTH+1)-1:0]    jq_cnt;
  logic                             oq_push, oq_full;
  logic [itpa_pkg::OUT_W-1:0]       oq_wdata, oq_rdata;
  logic [itpa_pkg::OUT_CNT_W-1:0]   oq_cnt;

  itpa_front #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .value     (in_value),
    .job_mag   (f_mag),
    .job_ctrl  (f_ctrl),
    .job_width (f_width)
  );

  assign jq_wdata = {f_mag, f_ctrl, f_width};

  itpa_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JQ_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (jq_wdata),
    .pop       (jq_pop),
    .pop_data  (jq_rdata),
    .full      (in_full),
    .empty     (jq_empty),
    .count     (jq_cnt)
  );

  assign {b_mag, b_ctrl, b_width} = jq_rdata;

  itpa_back #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!jq_empty && (jq_cnt != '0)),
    .job_pop   (jq_pop),
    .job_mag   (b_mag),
    .job_ctrl  (b_ctrl),
    .job_width (b_width),
    .out_cnt   (oq_cnt),
    .out_push  (oq_push),
    .out_data  (oq_wdata)
  );

  itpa_fifo #(
    .WIDTH (itpa_pkg::OUT_W),
    .DEPTH (itpa_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_wdata),
    .pop       (out_pop),
    .pop_data  (oq_rdata),
    .full      (oq_full),
    .empty     (out_empty),
    .count     (oq_cnt)
  );

  assign out_char_code = oq_rdata[itpa_pkg::OUT_W-1:1];
  assign out_last_char = oq_rdata[0] & ~oq_full | oq_rdata[0];

endmodule
